// ===== hdl/char_lcd_nibble_write_sequencer_unit_macros.svh =====
// assertion macros shared by the display sequencer rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_UNIT_MACROS_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define LCDSEQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define LCDSEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/lcdseq_pkg.sv =====
// types, codes and the sequence rom of the display sequencer
// no dependencies
package lcdseq_pkg;

	localparam int UNIT_TICKS_W  = 25;
	localparam int PULSE_UNITS_W = 8;
	localparam int UNITS_W       = 9;
	localparam int SEQ_PTR_W     = 5;
	localparam int PADDR_W       = 3;
	localparam int PDATA_W       = 32;

	// request codes
	localparam logic [2:0] REQ_TICK    = 3'd0;
	localparam logic [2:0] REQ_CMD     = 3'd1;
	localparam logic [2:0] REQ_DATA    = 3'd2;
	localparam logic [2:0] REQ_POWERUP = 3'd3;
	localparam logic [2:0] REQ_CLEAR   = 3'd4;

	// register index bit of paddr
	localparam logic REG_UNIT_TICKS  = 1'b0;
	localparam logic REG_PULSE_UNITS = 1'b1;

	localparam logic [UNIT_TICKS_W-1:0]  UNIT_TICKS_RESET  = 25'd7200;
	localparam logic [PULSE_UNITS_W-1:0] PULSE_UNITS_RESET = 8'd2;

	localparam logic [SEQ_PTR_W-1:0] POWERUP_START  = 5'd0;
	localparam logic [SEQ_PTR_W-1:0] PREAMBLE_START = 5'd20;

	typedef enum logic [1:0] {
		KIND_END  = 2'd0,
		KIND_WAIT = 2'd1,
		KIND_CMD  = 2'd2
	} rom_kind_t;

	typedef struct packed {
		rom_kind_t          kind;
		logic [UNITS_W-1:0] value;
	} rom_entry_t;

	// nibble phase: idle or sequence wait, then high/low nibble with enable high/low
	typedef enum logic [4:0] {
		PH_IDLE  = 5'b00001,
		PH_HI_EN = 5'b00010,
		PH_HI_LO = 5'b00100,
		PH_LO_EN = 5'b01000,
		PH_LO_LO = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [UNITS_W-1:0]   units_left;
		logic [SEQ_PTR_W-1:0] seq_ptr;
		phase_t               phase;
		logic [7:0]           cur_byte;
		logic                 is_data;
		logic                 rs;
		logic                 enable;
		logic [3:0]           nibble;
		logic                 busy;
		logic                 in_seq;
	} state_t;

	localparam state_t STATE_RESET = '{
		units_left: '0,
		seq_ptr:    '0,
		phase:      PH_IDLE,
		cur_byte:   '0,
		is_data:    1'b0,
		rs:         1'b0,
		enable:     1'b0,
		nibble:     '0,
		busy:       1'b0,
		in_seq:     1'b0
	};

	// power-up sequence from 0, clear / entry-mode / display-on preamble from 20
	function automatic rom_entry_t seq_rom(logic [SEQ_PTR_W-1:0] addr);
		rom_entry_t e;
		case (addr)
			5'd0:  e = '{KIND_WAIT, 9'd400};
			5'd1:  e = '{KIND_CMD,  9'h030};
			5'd2:  e = '{KIND_WAIT, 9'd45};
			5'd3:  e = '{KIND_CMD,  9'h030};
			5'd4:  e = '{KIND_WAIT, 9'd2};
			5'd5:  e = '{KIND_CMD,  9'h030};
			5'd6:  e = '{KIND_WAIT, 9'd2};
			5'd7:  e = '{KIND_CMD,  9'h020};
			5'd8:  e = '{KIND_WAIT, 9'd1};
			5'd9:  e = '{KIND_CMD,  9'h020};
			5'd10: e = '{KIND_WAIT, 9'd1};
			5'd11: e = '{KIND_CMD,  9'h008};
			5'd12: e = '{KIND_WAIT, 9'd1};
			5'd13: e = '{KIND_CMD,  9'h001};
			5'd14: e = '{KIND_WAIT, 9'd20};
			5'd15: e = '{KIND_CMD,  9'h006};
			5'd16: e = '{KIND_WAIT, 9'd1};
			5'd17: e = '{KIND_CMD,  9'h00f};
			5'd18: e = '{KIND_WAIT, 9'd1};
			5'd20: e = '{KIND_WAIT, 9'd1};
			5'd21: e = '{KIND_CMD,  9'h001};
			5'd22: e = '{KIND_WAIT, 9'd20};
			5'd23: e = '{KIND_CMD,  9'h006};
			5'd24: e = '{KIND_WAIT, 9'd1};
			5'd25: e = '{KIND_CMD,  9'h00f};
			5'd26: e = '{KIND_WAIT, 9'd1};
			default: e = '{KIND_END, 9'd0};
		endcase
		return e;
	endfunction

endpackage

// ===== hdl/lcdseq_step.sv =====
// next-state logic of the display sequencer for one item
// depends on lcdseq_pkg
module lcdseq_step #(
	parameter int TICK_COUNTER_WIDTH = 24
) (
	input  lcdseq_pkg::state_t                          state_cur,
	input  logic [TICK_COUNTER_WIDTH-1:0]               tick_cur,
	input  logic [2:0]                                  req_type,
	input  logic [7:0]                                  byte_value,
	input  logic [lcdseq_pkg::UNIT_TICKS_W-1:0]         unit_ticks,
	input  logic [lcdseq_pkg::PULSE_UNITS_W-1:0]        pulse_units,
	output lcdseq_pkg::state_t                          state_nxt,
	output logic [TICK_COUNTER_WIDTH-1:0]               tick_nxt,
	output logic                                        status
);

	localparam int CMP_W = (TICK_COUNTER_WIDTH + 1 > lcdseq_pkg::UNIT_TICKS_W) ?
		TICK_COUNTER_WIDTH + 1 : lcdseq_pkg::UNIT_TICKS_W;

	function automatic lcdseq_pkg::state_t start_byte(lcdseq_pkg::state_t s,
		logic [7:0] v, logic d, logic [lcdseq_pkg::UNITS_W-1:0] plen);
		lcdseq_pkg::state_t r;
		r            = s;
		r.cur_byte   = v;
		r.is_data    = d;
		r.rs         = d;
		r.nibble     = v[7:4];
		r.enable     = 1'b1;
		r.phase      = lcdseq_pkg::PH_HI_EN;
		r.busy       = 1'b1;
		r.units_left = plen;
		return r;
	endfunction

	function automatic lcdseq_pkg::state_t load_entry(lcdseq_pkg::state_t s,
		logic [lcdseq_pkg::SEQ_PTR_W-1:0] ptr, logic [lcdseq_pkg::UNITS_W-1:0] plen);
		lcdseq_pkg::state_t     r;
		lcdseq_pkg::rom_entry_t e;
		r         = s;
		e         = lcdseq_pkg::seq_rom(ptr);
		r.seq_ptr = ptr;
		case (e.kind)
			lcdseq_pkg::KIND_WAIT: begin
				r.phase      = lcdseq_pkg::PH_IDLE;
				r.busy       = 1'b1;
				r.units_left = e.value;
			end
			lcdseq_pkg::KIND_CMD: begin
				r = start_byte(r, e.value[7:0], 1'b0, plen);
			end
			default: begin
				r.phase      = lcdseq_pkg::PH_IDLE;
				r.busy       = 1'b0;
				r.in_seq     = 1'b0;
				r.units_left = '0;
			end
		endcase
		return r;
	endfunction

	function automatic lcdseq_pkg::state_t next_item(lcdseq_pkg::state_t s,
		logic [lcdseq_pkg::UNITS_W-1:0] plen);
		lcdseq_pkg::state_t r;
		r = s;
		if (s.in_seq) begin
			r = load_entry(s, s.seq_ptr + 5'd1, plen);
		end else begin
			r.busy       = 1'b0;
			r.phase      = lcdseq_pkg::PH_IDLE;
			r.units_left = '0;
		end
		return r;
	endfunction

	function automatic lcdseq_pkg::state_t finish_segment(lcdseq_pkg::state_t s,
		logic [lcdseq_pkg::UNITS_W-1:0] plen);
		lcdseq_pkg::state_t r;
		r = s;
		case (s.phase)
			lcdseq_pkg::PH_HI_EN: begin
				r.enable     = 1'b0;
				r.phase      = lcdseq_pkg::PH_HI_LO;
				r.units_left = plen;
			end
			lcdseq_pkg::PH_HI_LO: begin
				r.nibble     = s.cur_byte[3:0];
				r.enable     = 1'b1;
				r.phase      = lcdseq_pkg::PH_LO_EN;
				r.units_left = plen;
			end
			lcdseq_pkg::PH_LO_EN: begin
				r.enable     = 1'b0;
				r.phase      = lcdseq_pkg::PH_LO_LO;
				r.units_left = plen;
			end
			lcdseq_pkg::PH_LO_LO: begin
				// rs goes back high once a command byte is out
				if (!s.is_data) begin
					r.rs = 1'b1;
				end
				r.phase = lcdseq_pkg::PH_IDLE;
				r       = next_item(r, plen);
			end
			default: begin
				r.phase = lcdseq_pkg::PH_IDLE;
				r       = next_item(r, plen);
			end
		endcase
		return r;
	endfunction

	logic [lcdseq_pkg::UNITS_W-1:0] plen;
	logic [TICK_COUNTER_WIDTH:0]    tick_inc;
	logic                           unit_done;

	assign plen      = (pulse_units == '0) ? 9'd1 : {1'b0, pulse_units};
	assign tick_inc  = {1'b0, tick_cur} + 1'b1;
	assign unit_done = CMP_W'(tick_inc) >= CMP_W'(unit_ticks);

	always_comb begin
		state_nxt = state_cur;
		tick_nxt  = tick_cur;
		status    = 1'b0;
		case (req_type)
			lcdseq_pkg::REQ_TICK: begin
				if (state_cur.busy) begin
					if (unit_done) begin
						tick_nxt = '0;
						if (state_cur.units_left > 9'd1) begin
							state_nxt.units_left = state_cur.units_left - 9'd1;
						end else begin
							state_nxt = finish_segment(state_cur, plen);
						end
					end else begin
						tick_nxt = tick_inc[TICK_COUNTER_WIDTH-1:0];
					end
				end
			end
			lcdseq_pkg::REQ_CMD, lcdseq_pkg::REQ_DATA: begin
				if (state_cur.busy) begin
					status = 1'b1;
				end else begin
					state_nxt        = start_byte(state_cur, byte_value,
						req_type == lcdseq_pkg::REQ_DATA, plen);
					state_nxt.in_seq = 1'b0;
					tick_nxt         = '0;
				end
			end
			lcdseq_pkg::REQ_POWERUP, lcdseq_pkg::REQ_CLEAR: begin
				if (state_cur.busy) begin
					status = 1'b1;
				end else begin
					state_nxt.in_seq = 1'b1;
					state_nxt        = load_entry(state_nxt,
						(req_type == lcdseq_pkg::REQ_POWERUP) ?
						lcdseq_pkg::POWERUP_START : lcdseq_pkg::PREAMBLE_START, plen);
					tick_nxt         = '0;
				end
			end
			default: begin
				state_nxt = state_cur;
			end
		endcase
	end

endmodule

// ===== hdl/char_lcd_nibble_write_sequencer_unit.sv =====
// top level of the 4-bit character display sequencer: apb registers,
// item register, sequencer state and result register
// depends on lcdseq_pkg, lcdseq_step and the assertion macro header
//
// usage
// - item channel (req_valid/req_ready): req_type 0 is a timebase tick, 1 writes
//   a command byte, 2 writes a data byte, 3 runs the power-up sequence, 4 runs
//   the clear / entry-mode / display-on preamble; codes 5 to 7 are ignored
// - result channel (res_valid/res_ready): one result per item with the pin
//   levels after that item (rs, enable, nibble), busy, and status 1 when a
//   request came while busy and was dropped
// - apb port: unit_ticks at 0x0, pulse_units at 0x4; the user writes them only
//   while idle, which the block does not enforce; one item per cycle sustained
//   while res_ready stays high, set by the single next-state pass between the
//   item register and the state/result registers
// - a stalled receiver keeps the result register full; the item register
//   still takes one more item, and req_ready drops only when both are full
// - reset clears the sequencer to idle with rs, enable and nibble low,
//   unit_ticks to 7200 and pulse_units to 2
`include "char_lcd_nibble_write_sequencer_unit_macros.svh"

module char_lcd_nibble_write_sequencer_unit #(
	parameter int TICK_COUNTER_WIDTH = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// apb configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [lcdseq_pkg::PADDR_W-1:0]      paddr,
	input  logic [lcdseq_pkg::PDATA_W-1:0]      pwdata,
	output logic [lcdseq_pkg::PDATA_W-1:0]      prdata,
	output logic                                pready,
	// item channel
	input  logic                                req_valid,
	output logic                                req_ready,
	input  logic [2:0]                          req_type,
	input  logic [7:0]                          byte_value,
	// result channel
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic                                rs_level,
	output logic                                enable_level,
	output logic [3:0]                          data_nibble,
	output logic                                busy_res,
	output logic                                status
);

	// configuration registers
	logic [lcdseq_pkg::UNIT_TICKS_W-1:0]  unit_ticks_q;
	logic [lcdseq_pkg::PULSE_UNITS_W-1:0] pulse_units_q;
	logic                                 cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_ticks_q  <= lcdseq_pkg::UNIT_TICKS_RESET;
			pulse_units_q <= lcdseq_pkg::PULSE_UNITS_RESET;
		end else if (cfg_wr) begin
			// word index sits in paddr[2]
			if (paddr[2] == lcdseq_pkg::REG_UNIT_TICKS) begin
				unit_ticks_q <= pwdata[lcdseq_pkg::UNIT_TICKS_W-1:0];
			end else begin
				pulse_units_q <= pwdata[lcdseq_pkg::PULSE_UNITS_W-1:0];
			end
		end
	end

	assign prdata = (paddr[2] == lcdseq_pkg::REG_PULSE_UNITS) ?
		lcdseq_pkg::PDATA_W'(pulse_units_q) : lcdseq_pkg::PDATA_W'(unit_ticks_q);

	// item register (stage 1)
	logic       valid_s1;
	logic [2:0] req_type_s1;
	logic [7:0] byte_value_s1;
	logic       advance;

	// result register (stage 2)
	logic       valid_s2;
	logic       rs_s2;
	logic       enable_s2;
	logic [3:0] nibble_s2;
	logic       busy_s2;
	logic       status_s2;

	// the item in stage 1 moves on when the result register is free or drains
	assign advance   = valid_s1 && (!valid_s2 || res_ready);
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_type_s1   <= req_type;
			byte_value_s1 <= byte_value;
		end
	end

	// sequencer state, updated once per item as it leaves stage 1
	lcdseq_pkg::state_t              state_q;
	lcdseq_pkg::state_t              state_nxt;
	logic [TICK_COUNTER_WIDTH-1:0]   tick_count_q;
	logic [TICK_COUNTER_WIDTH-1:0]   tick_nxt;
	logic                            status_nxt;

	lcdseq_step #(
		.TICK_COUNTER_WIDTH(TICK_COUNTER_WIDTH)
	) u_step (
		.state_cur   (state_q),
		.tick_cur    (tick_count_q),
		.req_type    (req_type_s1),
		.byte_value  (byte_value_s1),
		.unit_ticks  (unit_ticks_q),
		.pulse_units (pulse_units_q),
		.state_nxt   (state_nxt),
		.tick_nxt    (tick_nxt),
		.status      (status_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= lcdseq_pkg::STATE_RESET;
			tick_count_q <= '0;
		end else if (advance) begin
			state_q      <= state_nxt;
			tick_count_q <= tick_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// pin levels after this item
	always_ff @(posedge clk) begin
		if (advance) begin
			rs_s2     <= state_nxt.rs;
			enable_s2 <= state_nxt.enable;
			nibble_s2 <= state_nxt.nibble;
			busy_s2   <= state_nxt.busy;
			status_s2 <= status_nxt;
		end
	end

	assign res_valid    = valid_s2;
	assign rs_level     = rs_s2;
	assign enable_level = enable_s2;
	assign data_nibble  = nibble_s2;
	assign busy_res     = busy_s2;
	assign status       = status_s2;

	// enable only pulses inside a byte
	`LCDSEQ_ASSERT_NOW(a_enable_busy, clk, arst_n, state_q.enable, state_q.busy, "enable high while idle")
	// a nibble phase or a running sequence always means busy
	`LCDSEQ_ASSERT_NOW(a_phase_busy, clk, arst_n, (state_q.phase != lcdseq_pkg::PH_IDLE) || state_q.in_seq, state_q.busy, "phase or sequence active while idle")
	// the tick counter rests at zero when idle
	`LCDSEQ_ASSERT_NOW(a_idle_tick, clk, arst_n, !state_q.busy, tick_count_q == '0, "tick count nonzero while idle")
	// a request taken while busy is reported as rejected
	`LCDSEQ_ASSERT_NEXT(a_reject, clk, arst_n, advance && state_q.busy && (req_type_s1 != lcdseq_pkg::REQ_TICK) && (req_type_s1 <= lcdseq_pkg::REQ_CLEAR), status_s2, "busy request not rejected")

endmodule

// ===== test/tb_char_lcd_nibble_write_sequencer_unit.sv =====
// self-checking bench for the 4-bit character display sequencer: a directed table, then
// random items under several register settings, checked against an in-bench display model
// depends on lcdseq_pkg and char_lcd_nibble_write_sequencer_unit
module tb_char_lcd_nibble_write_sequencer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import lcdseq_pkg::*;

	// codes the block ignores
	localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
	localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

	// register byte addresses
	localparam logic [PADDR_W-1:0] UNIT_ADDR  = {REG_UNIT_TICKS, 2'b00};
	localparam logic [PADDR_W-1:0] PULSE_ADDR = {REG_PULSE_UNITS, 2'b00};

	localparam int DIRECTED_ROWS  = 23;
	localparam int DIRECTED_SPLIT = 8;
	localparam int HOLD_CYCLES    = 200;
	localparam int SETTLE_CYCLES  = 8;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int PRINT_CAP      = 100;

	// pin levels and flags of one result item
	typedef struct packed {
		logic       rs;
		logic       en;
		logic [3:0] nib;
		logic       busy;
		logic       status;
	} lcd_pins_t;

	// one row of the directed table
	typedef struct packed {
		logic [2:0] code;
		logic [7:0] value;
		logic       typed;
		logic       drain;
		lcd_pins_t  pins;
	} probe_row_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	logic                req_valid;
	logic                req_ready;
	logic [2:0]          req_type;
	logic [7:0]          byte_value;
	logic                res_valid;
	logic                res_ready;
	logic                rs_level;
	logic                enable_level;
	logic [3:0]          data_nibble;
	logic                busy_res;
	logic                status;

	// expected result items, oldest first
	lcd_pins_t pins_due[$];
	int        fails;

	// both sides run without gaps while calm is set
	bit calm;
	// asks the result side for one long hold-off
	bit squeeze;

	// display model: registers
	logic [UNIT_TICKS_W-1:0]  unit_cfg;
	logic [PULSE_UNITS_W-1:0] pulse_cfg;
	// display model: sequencer state
	logic [23:0]          tick_cnt;
	logic [UNITS_W-1:0]   units_rem;
	logic [SEQ_PTR_W-1:0] ptr_q;
	phase_t               ph;
	logic [7:0]           byte_q;
	logic                 data_q;
	logic                 rs_q;
	logic                 en_q;
	logic [3:0]           nib_q;
	logic                 busy_q;
	logic                 seq_q;

	// directed table; pins are typed in where they follow at a glance,
	// drain runs ticks until the sequencer is idle again
	probe_row_t probe_rows [DIRECTED_ROWS] = '{
		// reset settings: idle tick and unknown codes change nothing
		'{REQ_TICK,      8'h00, 1'b1, 1'b0, '{1'b0, 1'b0, 4'h0, 1'b0, 1'b0}},
		'{REQ_UNUSED_HI, 8'hFF, 1'b1, 1'b0, '{1'b0, 1'b0, 4'h0, 1'b0, 1'b0}},
		'{REQ_UNUSED_LO, 8'h55, 1'b1, 1'b0, '{1'b0, 1'b0, 4'h0, 1'b0, 1'b0}},
		// command byte: rs low, high nibble out with enable high
		'{REQ_CMD,       8'hFF, 1'b1, 1'b0, '{1'b0, 1'b1, 4'hF, 1'b1, 1'b0}},
		// every request while busy is turned away
		'{REQ_DATA,      8'h00, 1'b1, 1'b0, '{1'b0, 1'b1, 4'hF, 1'b1, 1'b1}},
		'{REQ_POWERUP,   8'hAA, 1'b1, 1'b0, '{1'b0, 1'b1, 4'hF, 1'b1, 1'b1}},
		'{REQ_CLEAR,     8'h55, 1'b1, 1'b0, '{1'b0, 1'b1, 4'hF, 1'b1, 1'b1}},
		'{REQ_TICK,      8'hFF, 1'b0, 1'b1, '0},
		// one tick per unit and one unit per phase from here
		'{REQ_DATA,      8'h00, 1'b1, 1'b0, '{1'b1, 1'b1, 4'h0, 1'b1, 1'b0}},
		'{REQ_TICK,      8'hFF, 1'b0, 1'b0, '0},
		'{REQ_TICK,      8'h00, 1'b0, 1'b0, '0},
		'{REQ_TICK,      8'hFF, 1'b0, 1'b0, '0},
		'{REQ_TICK,      8'h00, 1'b0, 1'b0, '0},
		'{REQ_TICK,      8'hFF, 1'b0, 1'b0, '0},
		'{REQ_CMD,       8'hA5, 1'b1, 1'b0, '{1'b0, 1'b1, 4'hA, 1'b1, 1'b0}},
		'{REQ_TICK,      8'h00, 1'b0, 1'b0, '0},
		'{REQ_TICK,      8'hFF, 1'b0, 1'b0, '0},
		'{REQ_TICK,      8'h00, 1'b0, 1'b0, '0},
		// end of the command byte raises rs
		'{REQ_TICK,      8'hFF, 1'b0, 1'b0, '0},
		'{REQ_CLEAR,     8'h00, 1'b0, 1'b0, '0},
		'{REQ_CMD,       8'h3C, 1'b0, 1'b0, '0},
		'{REQ_POWERUP,   8'h00, 1'b0, 1'b1, '0},
		// full power-up sequence
		'{REQ_POWERUP,   8'hC3, 1'b0, 1'b1, '0}
	};

	char_lcd_nibble_write_sequencer_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req_type     (req_type),
		.byte_value   (byte_value),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.rs_level     (rs_level),
		.enable_level (enable_level),
		.data_nibble  (data_nibble),
		.busy_res     (busy_res),
		.status       (status)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// command and wait program: power-up from 0, clear preamble from 20
	function automatic rom_entry_t program_word(input logic [SEQ_PTR_W-1:0] addr);
		rom_entry_t w;
		w = '{KIND_END, 9'd0};
		case (addr)
			5'd0:  w = '{KIND_WAIT, 9'd400};
			5'd1:  w = '{KIND_CMD,  9'h030};
			5'd2:  w = '{KIND_WAIT, 9'd45};
			5'd3:  w = '{KIND_CMD,  9'h030};
			5'd4:  w = '{KIND_WAIT, 9'd2};
			5'd5:  w = '{KIND_CMD,  9'h030};
			5'd6:  w = '{KIND_WAIT, 9'd2};
			5'd7:  w = '{KIND_CMD,  9'h020};
			5'd8:  w = '{KIND_WAIT, 9'd1};
			5'd9:  w = '{KIND_CMD,  9'h020};
			5'd10: w = '{KIND_WAIT, 9'd1};
			5'd11: w = '{KIND_CMD,  9'h008};
			5'd12: w = '{KIND_WAIT, 9'd1};
			5'd13: w = '{KIND_CMD,  9'h001};
			5'd14: w = '{KIND_WAIT, 9'd20};
			5'd15: w = '{KIND_CMD,  9'h006};
			5'd16: w = '{KIND_WAIT, 9'd1};
			5'd17: w = '{KIND_CMD,  9'h00f};
			5'd18: w = '{KIND_WAIT, 9'd1};
			5'd20: w = '{KIND_WAIT, 9'd1};
			5'd21: w = '{KIND_CMD,  9'h001};
			5'd22: w = '{KIND_WAIT, 9'd20};
			5'd23: w = '{KIND_CMD,  9'h006};
			5'd24: w = '{KIND_WAIT, 9'd1};
			5'd25: w = '{KIND_CMD,  9'h00f};
			5'd26: w = '{KIND_WAIT, 9'd1};
			default: w = '{KIND_END, 9'd0};
		endcase
		return w;
	endfunction

	// a pulse setting of zero counts as one unit
	function automatic logic [UNITS_W-1:0] pulse_span();
		return (pulse_cfg == '0) ? UNITS_W'(1) : UNITS_W'(pulse_cfg);
	endfunction

	// every wait or nibble phase restarts the tick count
	function automatic void open_segment(input logic [UNITS_W-1:0] units);
		units_rem = units;
		tick_cnt  = '0;
	endfunction

	function automatic void launch_byte(input logic [7:0] value, input logic as_data);
		byte_q = value;
		data_q = as_data;
		rs_q   = as_data;
		nib_q  = value[7:4];
		en_q   = 1'b1;
		ph     = PH_HI_EN;
		busy_q = 1'b1;
		open_segment(pulse_span());
	endfunction

	function automatic void enter_program_step();
		rom_entry_t w;
		w = program_word(ptr_q);
		case (w.kind)
			KIND_WAIT: begin
				ph     = PH_IDLE;
				busy_q = 1'b1;
				open_segment(w.value);
			end
			KIND_CMD: launch_byte(w.value[7:0], 1'b0);
			default: begin
				ph        = PH_IDLE;
				busy_q    = 1'b0;
				seq_q     = 1'b0;
				units_rem = '0;
				tick_cnt  = '0;
			end
		endcase
	endfunction

	// after a byte or a wait: next program step, or back to idle
	function automatic void close_item();
		if (seq_q) begin
			ptr_q = ptr_q + 1'b1;
			enter_program_step();
		end else begin
			busy_q    = 1'b0;
			ph        = PH_IDLE;
			units_rem = '0;
			tick_cnt  = '0;
		end
	endfunction

	// advances the display model by one item and returns the pins after it
	function automatic lcd_pins_t step_display(input logic [2:0] code, input logic [7:0] value);
		logic                    rejected;
		logic [UNIT_TICKS_W-1:0] nxt;
		rejected = 1'b0;
		case (code)
			REQ_TICK: begin
				// ticks while idle leave the count at zero
				if (busy_q) begin
					nxt = {1'b0, tick_cnt} + 1'b1;
					if (nxt >= unit_cfg) begin
						tick_cnt = '0;
						if (units_rem > 1)
							units_rem = units_rem - 1'b1;
						else begin
							case (ph)
								PH_HI_EN: begin
									en_q = 1'b0;
									ph   = PH_HI_LO;
									open_segment(pulse_span());
								end
								PH_HI_LO: begin
									nib_q = byte_q[3:0];
									en_q  = 1'b1;
									ph    = PH_LO_EN;
									open_segment(pulse_span());
								end
								PH_LO_EN: begin
									en_q = 1'b0;
									ph   = PH_LO_LO;
									open_segment(pulse_span());
								end
								PH_LO_LO: begin
									// commands leave rs high
									if (!data_q)
										rs_q = 1'b1;
									ph = PH_IDLE;
									close_item();
								end
								default: begin
									ph = PH_IDLE;
									close_item();
								end
							endcase
						end
					end else begin
						tick_cnt = nxt[23:0];
					end
				end
			end
			REQ_CMD, REQ_DATA: begin
				if (busy_q)
					rejected = 1'b1;
				else begin
					seq_q = 1'b0;
					launch_byte(value, code == REQ_DATA);
				end
			end
			REQ_POWERUP, REQ_CLEAR: begin
				if (busy_q)
					rejected = 1'b1;
				else begin
					seq_q = 1'b1;
					ptr_q = (code == REQ_POWERUP) ? POWERUP_START : PREAMBLE_START;
					enter_program_step();
				end
			end
			default: ;
		endcase
		return '{rs_q, en_q, nib_q, busy_q, rejected};
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			fails++;
			if (fails <= PRINT_CAP)
				$display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	// offers one item, waits for the handshake, then books its expected pins;
	// returns at the falling edge after acceptance with valid still high
	task automatic send_item(input logic [2:0] code, input logic [7:0] value, input logic typed,
			input lcd_pins_t typed_pins);
		lcd_pins_t forecast;
		if (!calm && $urandom_range(99) < 10) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		req_valid  <= 1'b1;
		req_type   <= code;
		byte_value <= value;
		do @(posedge clk); while (!req_ready);
		forecast = step_display(code, value);
		pins_due.push_back(typed ? typed_pins : forecast);
		@(negedge clk);
	endtask

	// ticks until the model says the sequencer is idle
	task automatic tick_until_idle();
		while (busy_q)
			send_item(REQ_TICK, 8'($urandom_range(255)), 1'b0, '0);
	endtask

	// register write once all results are in, then read back
	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
		logic [31:0] keep;
		req_valid <= 1'b0;
		wait (pins_due.size() == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == UNIT_ADDR)
			unit_cfg = data[UNIT_TICKS_W-1:0];
		else
			pulse_cfg = data[PULSE_UNITS_W-1:0];
		keep = (addr == UNIT_ADDR) ? 32'h01FF_FFFF : 32'h0000_00FF;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("prdata", data & keep, prdata);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// random items: mostly ticks while busy so bytes and sequences run to the end,
	// mostly requests while idle; rejected requests and unknown codes mixed in
	task automatic run_random(input int count, input bit allow_long);
		logic [2:0]  code;
		logic [7:0]  value;
		int unsigned roll;
		int unsigned pick;
		repeat (count) begin
			roll  = $urandom_range(99);
			pick  = $urandom_range(99);
			value = 8'($urandom_range(255));
			if (busy_q) begin
				if (roll < 84)
					code = REQ_TICK;
				else if (roll < 94)
					code = 3'($urandom_range(REQ_CMD, REQ_CLEAR));
				else
					code = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
			end else if (roll < 15) begin
				code = REQ_TICK;
			end else if (roll < 25) begin
				code = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
			end else if (pick < 42) begin
				code = REQ_CMD;
			end else if (pick < 84) begin
				code = REQ_DATA;
			end else if (pick < 94) begin
				code = allow_long ? REQ_CLEAR : REQ_CMD;
			end else begin
				code = allow_long ? REQ_POWERUP : REQ_DATA;
			end
			send_item(code, value, 1'b0, '0);
		end
	endtask

	// result side: random stalls, one long hold-off on request
	initial begin : result_sink
		res_ready = 1'b1;
		forever begin
			@(negedge clk);
			if (squeeze) begin
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				squeeze = 1'b0;
			end
			res_ready <= calm || ($urandom_range(99) >= 10);
		end
	end

	// compare each result item with the oldest expectation
	always @(posedge clk) begin : result_check
		lcd_pins_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pins_due.size() == 0) begin
				fails++;
				if (fails <= PRINT_CAP)
					$display("%0t unexpected item: expected none, actual rs %0b en %0b nib %0h busy %0b st %0b",
						$time, rs_level, enable_level, data_nibble, busy_res, status);
			end else begin
				want = pins_due.pop_front();
				check_field("rs_level", want.rs, rs_level);
				check_field("enable_level", want.en, enable_level);
				check_field("data_nibble", want.nib, data_nibble);
				check_field("busy_res", want.busy, busy_res);
				check_field("status", want.status, status);
			end
		end
	end

	// cycle budget for the whole run
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		req_valid  = 1'b0;
		req_type   = REQ_TICK;
		byte_value = '0;
		calm       = 1'b0;
		squeeze    = 1'b0;
		fails      = 0;
		// model state after reset
		unit_cfg  = UNIT_TICKS_RESET;
		pulse_cfg = PULSE_UNITS_RESET;
		tick_cnt  = '0;
		units_rem = '0;
		ptr_q     = '0;
		ph        = PH_IDLE;
		byte_q    = '0;
		data_q    = 1'b0;
		rs_q      = 1'b0;
		en_q      = 1'b0;
		nib_q     = '0;
		busy_q    = 1'b0;
		seq_q     = 1'b0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed rows: reset settings first, then one tick per unit and phase
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (i == DIRECTED_SPLIT) begin
				apb_write(UNIT_ADDR, 32'd1);
				apb_write(PULSE_ADDR, 32'd1);
			end
			send_item(probe_rows[i].code, probe_rows[i].value, probe_rows[i].typed,
				probe_rows[i].pins);
			if (probe_rows[i].drain)
				tick_until_idle();
		end

		// zero settings behave as one; no gaps on either side here
		apb_write(UNIT_ADDR, 32'd0);
		apb_write(PULSE_ADDR, 32'd0);
		calm = 1'b1;
		run_random(120, 1'b1);
		tick_until_idle();
		calm = 1'b0;

		// result side holds off while items keep coming, so the input stalls
		apb_write(UNIT_ADDR, 32'd3);
		apb_write(PULSE_ADDR, 32'd2);
		run_random(40, 1'b1);
		squeeze = 1'b1;
		run_random(210, 1'b1);
		tick_until_idle();

		// longest enable pulse
		apb_write(UNIT_ADDR, 32'd1);
		apb_write(PULSE_ADDR, 32'd255);
		run_random(150, 1'b1);
		tick_until_idle();

		// longest unit: only a few ticks fit, then a shorter unit lets the byte finish;
		// the tick count stays below the new setting so the switch is clean
		apb_write(UNIT_ADDR, 32'd16777216);
		apb_write(PULSE_ADDR, 32'd1);
		run_random(40, 1'b0);
		apb_write(UNIT_ADDR, 32'd64);
		tick_until_idle();

		apb_write(UNIT_ADDR, 32'd2);
		apb_write(PULSE_ADDR, 32'd1);
		run_random(150, 1'b1);
		tick_until_idle();

		// drain the result queue, then let the pipeline settle
		req_valid <= 1'b0;
		wait (pins_due.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
